/* sv/oist_pkg.sv */
package oist_pkg;

	// number of entries the table holds
	localparam int unsigned CAPACITY = 16;
	// entry index and fill count widths
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	// field widths fixed by the interface
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOCHANGE = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture command and lookup result
		logic update;  // apply command, load result register
	} oist_cmd_t;

endpackage

/* sv/ordered_integer_set_table.sv */
// ordered integer set table: holds up to CAPACITY (16) distinct 32-bit values in the
// order they were added. each command (add, remove, query, clear) returns one result
// with a status, a found flag (value was a member before the command) and the count
// after the command. on the input transfer the value is compared against every live
// entry at once and the first match is registered; the update state that follows
// applies the append, the gap-closing shift or the clear and loads the result register.
// the block takes one command at a time; a finished result waits in its own register,
// so the next command is taken while the result is still pending, and only the update
// cycle stalls until that result transfer has happened.
// entries are not cleared at reset; only the fill count is, and entries at or above
// it are never compared
module ordered_integer_set_table import oist_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                found,
	output logic [4:0]          count
);

	oist_cmd_t cmd;

	// sequencing of capture and update, result transfer tracking
	oist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// entry storage, compare array and result register
	oist_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.mode   (mode),
		.value  (value),
		.status (status),
		.found  (found),
		.count  (count)
	);

endmodule

/* sv/oist_ctrl.sv */
module oist_ctrl import oist_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output oist_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   res_free;

	// result register can take a new result this cycle
	assign res_free = !out_valid_q || out_ready;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.load   = in_valid && (state_q == S_IDLE);
	assign cmd.update = (state_q == S_UPD) && res_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_ready) out_valid_q <= 1'b0;
					if (in_valid) state_q <= S_UPD;
				end
				S_UPD: begin
					if (res_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.update))
		else $error("load and update in the same cycle");

	a_load_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_UPD))
		else $error("accepted command did not move to update");

	a_upd_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid_q)
		else $error("update produced no result");

endmodule

/* sv/oist_dp.sv */
module oist_dp import oist_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  oist_cmd_t           cmd,
	input  logic [1:0]          mode,
	input  logic [VALUE_W-1:0]  value,
	output logic [1:0]          status,
	output logic                found,
	output logic [COUNT_W-1:0]  count
);

	logic [VALUE_W-1:0] mem_q [CAPACITY];
	logic [CNT_W-1:0]   cnt_q;

	mode_t              mode_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               found_s1;
	logic [IDX_W-1:0]   pos_s1;

	status_t            status_q;
	logic               found_q;
	logic [COUNT_W-1:0] count_q;

	logic [CAPACITY-1:0] match;
	logic                hit;
	logic [IDX_W-1:0]    pos;
	logic                full;
	logic                do_add;
	logic                do_rem;
	status_t             status_nxt;
	logic [CNT_W-1:0]    cnt_nxt;

	// parallel compare of the incoming value against all live entries
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CNT_W'(i) < cnt_q) && (mem_q[i] == value);
		end
	end

	assign hit = |match;

	// lowest matching index
	always_comb begin
		pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) pos = IDX_W'(i);
		end
	end

	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign do_add = (mode_s1 == MODE_ADD) && !full && !found_s1;
	assign do_rem = (mode_s1 == MODE_REMOVE) && found_s1;

	always_comb begin
		status_nxt = ST_DONE;
		cnt_nxt    = cnt_q;
		case (mode_s1)
			MODE_ADD: begin
				if (full) status_nxt = ST_FULL;
				else if (found_s1) status_nxt = ST_NOCHANGE;
				else cnt_nxt = cnt_q + 1'b1;
			end
			MODE_REMOVE: begin
				if (!found_s1) status_nxt = ST_NOCHANGE;
				else cnt_nxt = cnt_q - 1'b1;
			end
			MODE_QUERY: begin
				status_nxt = ST_DONE;
			end
			MODE_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
				status_nxt = ST_DONE;
			end
		endcase
	end

	// command capture and lookup result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_s1  <= mode_t'(mode);
			value_s1 <= value;
			found_s1 <= hit;
			pos_s1   <= pos;
		end
	end

	// entry storage: append at the tail, or close the gap on remove
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (do_add && (CNT_W'(i) == cnt_q)) begin
					mem_q[i] <= value_s1;
				end else if (do_rem && (IDX_W'(i) >= pos_s1) && (i < CAPACITY - 1)) begin
					mem_q[i] <= mem_q[(i + 1) % CAPACITY];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.update) begin
			cnt_q <= cnt_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			status_q <= status_nxt;
			found_q  <= found_s1;
			count_q  <= COUNT_W'(cnt_nxt);
		end
	end

	assign status = status_q;
	assign found  = found_q;
	assign count  = count_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && do_add) |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
		else $error("successful add did not grow the count");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && do_rem) |=> (cnt_q == CNT_W'($past(cnt_q) - 1'b1)))
		else $error("successful remove did not shrink the count");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && (mode_s1 == MODE_CLEAR)) |=> (cnt_q == '0))
		else $error("clear left entries");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import oist_pkg::*;

	// one reply as the block reports it
	typedef struct packed {
		status_t              status;
		logic                 found;
		logic [COUNT_W-1:0]   count;
	} set_reply_t;

	// one row of the directed plan; value steps up by one on each repeat
	typedef struct packed {
		mode_t        mode;
		logic [31:0]  value;
		logic [7:0]   reps;
		logic         typed;   // reply below is checked as written
		set_reply_t   reply;
	} plan_row_t;

	localparam int PLAN_ROWS  = 13;
	localparam int RAND_ITEMS = 1324;
	localparam int POOL_SIZE  = 20;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          mode;
	logic signed [31:0]  value;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          status;
	logic                found;
	logic [4:0]          count;

	ordered_integer_set_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.found     (found),
		.count     (count)
	);

	// shadow copy of the table: entries in insertion order and the fill count
	logic [31:0]  shadow_entries [CAPACITY];
	int           shadow_fill;

	// replies still owed by the block, oldest first
	set_reply_t   owed_replies [$];
	int           mismatches;
	// while set, neither side inserts idle cycles
	bit           calm;
	// values the random part draws from, so hits and a full table are common
	logic [31:0]  value_pool [POOL_SIZE];

	// directed plan: empty-table corners, extremes, filling up, the full table,
	// removal at both ends and clear of a member
	plan_row_t plan [PLAN_ROWS] = '{
		'{MODE_QUERY,  32'hFFFF_FFFF, 8'd1,  1'b1, '{ST_DONE,     1'b0, 5'd0}},
		'{MODE_REMOVE, 32'h8000_0000, 8'd1,  1'b1, '{ST_NOCHANGE, 1'b0, 5'd0}},
		'{MODE_CLEAR,  32'h0000_0000, 8'd1,  1'b1, '{ST_DONE,     1'b0, 5'd0}},
		'{MODE_ADD,    32'h8000_0000, 8'd1,  1'b1, '{ST_DONE,     1'b0, 5'd1}},
		'{MODE_ADD,    32'h7FFF_FFFF, 8'd1,  1'b1, '{ST_DONE,     1'b0, 5'd2}},
		'{MODE_ADD,    32'h7FFF_FFFF, 8'd1,  1'b1, '{ST_NOCHANGE, 1'b1, 5'd2}},
		// fourteen fresh values bring the table to capacity
		'{MODE_ADD,    32'h0000_0000, 8'd14, 1'b0, '{ST_DONE,     1'b0, 5'd0}},
		// full table: the full answer wins even for a member
		'{MODE_ADD,    32'h7FFF_FFFF, 8'd1,  1'b1, '{ST_FULL,     1'b1, 5'd16}},
		'{MODE_ADD,    32'hFFFF_FFFF, 8'd1,  1'b1, '{ST_FULL,     1'b0, 5'd16}},
		// first entry out, everything behind it shifts down
		'{MODE_REMOVE, 32'h8000_0000, 8'd1,  1'b0, '{ST_DONE,     1'b0, 5'd0}},
		'{MODE_REMOVE, 32'h0000_000D, 8'd1,  1'b0, '{ST_DONE,     1'b0, 5'd0}},
		'{MODE_QUERY,  32'h0000_0005, 8'd1,  1'b0, '{ST_DONE,     1'b0, 5'd0}},
		// clear still reports whether the value was a member
		'{MODE_CLEAR,  32'h7FFF_FFFF, 8'd1,  1'b1, '{ST_DONE,     1'b1, 5'd0}}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// apply one command to the shadow table and return the reply it earns
	function automatic set_reply_t apply_set_cmd(mode_t cmd, logic [31:0] v);
		set_reply_t  r;
		int          pos;
		bit          hit;
		pos = shadow_fill;
		for (int i = 0; i < shadow_fill; i++)
			if (shadow_entries[i] == v && pos == shadow_fill)
				pos = i;
		hit = (pos < shadow_fill);
		r.status = ST_DONE;
		r.found = hit;
		case (cmd)
			MODE_ADD: begin
				// full check comes before the membership check
				if (shadow_fill >= int'(CAPACITY))
					r.status = ST_FULL;
				else if (hit)
					r.status = ST_NOCHANGE;
				else begin
					shadow_entries[shadow_fill] = v;
					shadow_fill++;
				end
			end
			MODE_REMOVE: begin
				if (!hit)
					r.status = ST_NOCHANGE;
				else begin
					// close the gap, keeping the order of the rest
					for (int i = pos; i < shadow_fill - 1; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_fill--;
				end
			end
			MODE_QUERY: begin
			end
			default: begin
				shadow_fill = 0;
			end
		endcase
		r.count = shadow_fill[COUNT_W-1:0];
		return r;
	endfunction

	// idle cycles ahead of the next transfer: mostly none or a few, now and then many
	function automatic int pick_gap();
		int  r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// called at a clock edge; returns at the edge where the command transfer happens
	task automatic issue_cmd(mode_t cmd, logic [31:0] v, int gap, bit typed,
			set_reply_t typed_reply);
		set_reply_t  predicted;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= cmd;
		value <= v;
		do @(posedge clk); while (!in_ready);
		predicted = apply_set_cmd(cmd, v);
		owed_replies.push_back(typed ? typed_reply : predicted);
	endtask

	// hold the sender off until the block has answered everything
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_replies.size() != 0)
			@(posedge clk);
	endtask

	// random command: mostly adds and removes over a small pool of values
	// plus existing members, some queries, rare clears and fully random values
	task automatic issue_random_cmd();
		mode_t        cmd;
		logic [31:0]  v;
		int           r;
		r = $urandom_range(0, 99);
		if (r < 45)
			cmd = MODE_ADD;
		else if (r < 70)
			cmd = MODE_REMOVE;
		else if (r < 97)
			cmd = MODE_QUERY;
		else
			cmd = MODE_CLEAR;
		r = $urandom_range(0, 99);
		if (r < 60)
			v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 82 && shadow_fill > 0)
			v = shadow_entries[$urandom_range(0, shadow_fill - 1)];
		else
			v = $urandom;
		issue_cmd(cmd, v, pick_gap(), 1'b0, '0);
	endtask

	// sink side: random stalls on out_ready, none while calm
	always @(posedge clk) begin
		int  hold;
		int  r;
		if (hold > 0) begin
			hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			r = $urandom_range(0, 99);
			if (calm || r < 65)
				hold = 0;
			else if (r < 93)
				hold = $urandom_range(1, 3);
			else
				hold = $urandom_range(8, 40);
		end
	end

	// result check: every transfer is matched against the oldest owed reply
	always @(posedge clk) begin
		set_reply_t  want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status=%0d found=%0d count=%0d",
						status, found, count);
			end else begin
				want = owed_replies.pop_front();
				if (status !== want.status || found !== want.found
						|| count !== want.count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("result mismatch: expected status=%0d found=%0d count=%0d",
							want.status, want.found, want.count);
						$display(", got status=%0d found=%0d count=%0d",
							status, found, count);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ADD;
		value = '0;
		mismatches = 0;
		calm = 1'b0;
		shadow_fill = 0;
		foreach (shadow_entries[i])
			shadow_entries[i] = '0;
		// extremes always in the pool, the rest random
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		foreach (plan[i])
			for (int k = 0; k < int'(plan[i].reps); k++)
				issue_cmd(plan[i].mode, plan[i].value + k, pick_gap(),
					plan[i].typed, plan[i].reply);

		// random part, in segments that are sometimes free of idling
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (n == 600)
				drain_replies();
			issue_random_cmd();
		end

		in_valid <= 1'b0;
		while (owed_replies.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
